// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker module.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define SJPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define SJPL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== src/sjpl_pkg.sv =====
package sjpl_pkg;

  localparam int LABEL_BITS   = 16;
  localparam int INDEX_BITS   = 24;
  localparam int WIDTH_BITS   = 13;
  localparam int COL_BITS     = 12;
  localparam int COUNT_BITS   = 3;
  localparam int MAX_WIDTH    = 4096;
  localparam int DIV_STAGES   = 6;
  localparam int STEP_BITS    = (INDEX_BITS + DIV_STAGES - 1) / DIV_STAGES;
  localparam int NUM_STAGES   = DIV_STAGES + 1;
  localparam int SORT_LAYERS  = 3;
  localparam int KEY_BITS     = LABEL_BITS + 1;
  localparam int PAIR_BITS    = 3;

  typedef logic [LABEL_BITS-1:0] label_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [WIDTH_BITS-1:0] width_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [PAIR_BITS-1:0]  pair_idx_t;

  typedef struct packed {
    index_t pixel_index;
    label_t label_a;
    label_t label_b;
    label_t label_c;
    label_t label_d;
  } in_req_t;

  typedef struct packed {
    label_t                pair_first;
    label_t                pair_second;
    logic [COL_BITS-1:0]   col;
    index_t                row;
    count_t                label_count;
    logic                  junction;
    logic                  last_pair;
  } out_res_t;

  // A key carries an "absent" flag above the label so that uncounted labels sort last.
  typedef struct packed {
    key_t [3:0] key;
    count_t     count;
    logic       junc;
    width_t     rem;
    index_t     dq;
  } stage_t;

  typedef struct packed {
    logic [1:0] first;
    logic [1:0] second;
    logic       last;
  } pair_sel_t;

  function automatic width_t clamp_width(width_t raw);
    width_t w;
    if (raw == '0) begin
      w = width_t'(1);
    end else if (raw > width_t'(MAX_WIDTH)) begin
      w = width_t'(MAX_WIDTH);
    end else begin
      w = raw;
    end
    return w;
  endfunction

  function automatic key_t key_min(key_t x, key_t y);
    return (x < y) ? x : y;
  endfunction

  function automatic key_t key_max(key_t x, key_t y);
    return (x < y) ? y : x;
  endfunction

  // One layer of the four-input sorting network.
  function automatic stage_t sort_layer(stage_t s, int layer);
    stage_t r;
    r = s;
    case (layer)
      0: begin
        r.key[0] = key_min(s.key[0], s.key[1]);
        r.key[1] = key_max(s.key[0], s.key[1]);
        r.key[2] = key_min(s.key[2], s.key[3]);
        r.key[3] = key_max(s.key[2], s.key[3]);
      end
      1: begin
        r.key[0] = key_min(s.key[0], s.key[2]);
        r.key[2] = key_max(s.key[0], s.key[2]);
        r.key[1] = key_min(s.key[1], s.key[3]);
        r.key[3] = key_max(s.key[1], s.key[3]);
      end
      2: begin
        r.key[1] = key_min(s.key[1], s.key[2]);
        r.key[2] = key_max(s.key[1], s.key[2]);
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  // Restoring division: a few quotient bits per pipeline stage.
  function automatic stage_t div_step(stage_t s, width_t w, int stage_idx);
    stage_t r;
    width_t t;
    r = s;
    for (int j = 0; j < STEP_BITS; j++) begin
      if (stage_idx * STEP_BITS + j < INDEX_BITS) begin
        t = {r.rem[WIDTH_BITS-2:0], r.dq[INDEX_BITS-1]};
        r.dq = {r.dq[INDEX_BITS-2:0], 1'b0};
        if (t >= w) begin
          t = t - w;
          r.dq[0] = 1'b1;
        end
        r.rem = t;
      end
    end
    return r;
  endfunction

  // Maps the pair number to sorted positions, in the order (0,1), (0,2), ..., (n-2,n-1).
  function automatic pair_sel_t pair_select(count_t count, pair_idx_t idx);
    pair_sel_t p;
    p = '{first: 2'd0, second: 2'd1, last: 1'b1};
    case (count)
      3'd3: begin
        case (idx)
          3'd0:    p = '{first: 2'd0, second: 2'd1, last: 1'b0};
          3'd1:    p = '{first: 2'd0, second: 2'd2, last: 1'b0};
          default: p = '{first: 2'd1, second: 2'd2, last: 1'b1};
        endcase
      end
      3'd4: begin
        case (idx)
          3'd0:    p = '{first: 2'd0, second: 2'd1, last: 1'b0};
          3'd1:    p = '{first: 2'd0, second: 2'd2, last: 1'b0};
          3'd2:    p = '{first: 2'd0, second: 2'd3, last: 1'b0};
          3'd3:    p = '{first: 2'd1, second: 2'd2, last: 1'b0};
          3'd4:    p = '{first: 2'd1, second: 2'd3, last: 1'b0};
          default: p = '{first: 2'd2, second: 2'd3, last: 1'b1};
        endcase
      end
      default: begin
        p = '{first: 2'd0, second: 2'd1, last: 1'b1};
      end
    endcase
    return p;
  endfunction

endpackage

// ===== src/skeleton_junction_pair_lister.sv =====
// A pixel request is taken when start is high and busy is low; it passes an input register,
// six divider stages (which also sort the labels in the first three), a pair emitter and an
// output register before its first result is on out_res. A pixel gives one, three or six
// results, one per cycle on out_strobe, which must be taken when shown since the receiver
// cannot stall. The pair emitter sets the rate: the pipeline holds, and busy is high, while
// the emitter still has pairs of an earlier pixel to send, so sustained input is bounded by
// how many pairs each pixel gives according to its label count.
module skeleton_junction_pair_lister (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [sjpl_pkg::WIDTH_BITS-1:0]       cfg_wdata,
  input  logic                                  start,
  output logic                                  busy,
  input  sjpl_pkg::in_req_t                     in_req,
  output logic                                  out_strobe,
  output sjpl_pkg::out_res_t                    out_res
);
  import sjpl_pkg::*;

  width_t                  width_r;
  stage_t                  st_r   [NUM_STAGES];
  stage_t                  st_nxt [NUM_STAGES];
  logic [NUM_STAGES-1:0]   vld_r;
  logic                    adv;
  stage_t                  em_r;
  logic                    em_vld_r;
  pair_idx_t               em_pair_r;
  logic                    em_take;
  pair_sel_t               sel;
  logic                    out_strobe_r;
  out_res_t                out_res_r;
  out_res_t                out_res_nxt;
  logic                    c_present;
  logic                    d_present;

  assign c_present = (in_req.label_c != '0);
  assign d_present = c_present && (in_req.label_d != '0);

  always_comb begin
    st_nxt[0].key[0] = {1'b0, in_req.label_a};
    st_nxt[0].key[1] = {1'b0, in_req.label_b};
    st_nxt[0].key[2] = {!c_present, in_req.label_c};
    st_nxt[0].key[3] = {!d_present, in_req.label_d};
    st_nxt[0].count  = d_present ? 3'd4 : (c_present ? 3'd3 : 3'd2);
    st_nxt[0].junc   = c_present;
    st_nxt[0].rem    = '0;
    st_nxt[0].dq     = in_req.pixel_index;
    for (int k = 1; k < NUM_STAGES; k++) begin
      st_nxt[k] = st_r[k-1];
      if (k <= SORT_LAYERS) begin
        st_nxt[k] = sort_layer(st_nxt[k], k - 1);
      end
      st_nxt[k] = div_step(st_nxt[k], width_r, k - 1);
    end
  end

  assign sel     = pair_select(em_r.count, em_pair_r);
  assign em_take = !em_vld_r || sel.last;
  assign adv     = !vld_r[NUM_STAGES-1] || em_take;
  assign busy    = !adv;

  always_comb begin
    out_res_nxt.pair_first  = em_r.key[sel.first][LABEL_BITS-1:0];
    out_res_nxt.pair_second = em_r.key[sel.second][LABEL_BITS-1:0];
    out_res_nxt.col         = em_r.rem[COL_BITS-1:0];
    out_res_nxt.row         = em_r.dq;
    out_res_nxt.label_count = em_r.count;
    out_res_nxt.junction    = em_r.junc;
    out_res_nxt.last_pair   = sel.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= width_t'(1);
      vld_r        <= '0;
      em_vld_r     <= 1'b0;
      em_pair_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        width_r <= clamp_width(cfg_wdata);
      end
      if (adv) begin
        vld_r <= {vld_r[NUM_STAGES-2:0], start};
      end
      if (em_take) begin
        em_vld_r  <= vld_r[NUM_STAGES-1];
        em_pair_r <= '0;
      end else begin
        em_pair_r <= em_pair_r + pair_idx_t'(1);
      end
      out_strobe_r <= em_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
    if (em_take) begin
      em_r <= st_r[NUM_STAGES-1];
    end
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule

// ===== src/sjpl_checker.sv =====
`include "assert_macros.svh"

module sjpl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_strobe,
  input sjpl_pkg::out_res_t out_res
);
  import sjpl_pkg::*;

  `SJPL_ASSERT(a_count_range, out_strobe |-> (out_res.label_count == 3'd2 || out_res.label_count == 3'd3 || out_res.label_count == 3'd4), "label count out of range")
  `SJPL_ASSERT_NEVER(a_pair_order, out_strobe && (out_res.pair_first > out_res.pair_second), "pair labels not ascending")
  `SJPL_ASSERT(a_junction, out_strobe |-> (out_res.junction == (out_res.label_count != 3'd2)), "junction flag disagrees with label count")
  `SJPL_ASSERT(a_burst, out_strobe && !out_res.last_pair |=> out_strobe && $stable(out_res.row) && $stable(out_res.col), "pairs of one pixel are not contiguous")

endmodule

bind skeleton_junction_pair_lister sjpl_checker u_sjpl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_res    (out_res)
);
